[sv/mi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi_pkg
// Shared types and sequencer codes for the modular inverse unit.
// ----------------------------------------------------------------------------
package mi_pkg;

  // sequencer state vector
  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE   = 3'd0;
  localparam state_t ST_CHECK  = 3'd1;
  localparam state_t ST_DIV    = 3'd2;
  localparam state_t ST_UPDATE = 3'd3;
  localparam state_t ST_FINAL  = 3'd4;

endpackage : mi_pkg

`default_nettype wire

[sv/mi_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi_req_if
// Request channel: operand and modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mi_req_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] operand;
  logic [WORD_BITS-1:0] modulus;

  modport source (output valid, output operand, output modulus, input ready);
  modport sink   (input valid, input operand, input modulus, output ready);
endinterface : mi_req_if

`default_nettype wire

[sv/mi_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mi_rsp_if
// Response channel: reduced inverse with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mi_rsp_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface : mi_rsp_if

`default_nettype wire

[sv/modular_inverse_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_unit
// Modular inverse by the iterative extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// One request carries an operand and a modulus; one response returns the
// Bezout coefficient of the operand reduced into 0 .. modulus-1 (the inverse
// when the two are coprime, with no flag otherwise; modulus one or zero gives
// 0). Each Euclid round runs one restoring divide that yields one quotient bit
// per cycle, and the same cycle shifts and adds the coefficient product; a
// round is a test, WORD_BITS divide steps and an update. For 32-bit words a
// request takes at most about 47 rounds. The request side is ready only while
// the sequencer is idle; a finished response sits in an output register until
// taken, and the next request may be accepted meanwhile.
// ----------------------------------------------------------------------------
module modular_inverse_unit
  import mi_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  wire     clk,
  input  wire     rst,
  mi_req_if.sink  req,
  mi_rsp_if.source rsp
);

  // coefficients stay within +/- modulus, two extra bits hold sign and range
  localparam int CW       = WORD_BITS + 2;
  localparam int CNT_BITS = $clog2(WORD_BITS);

  state_t                state;
  logic [WORD_BITS-1:0]  r0;
  logic [WORD_BITS-1:0]  r1;
  logic [WORD_BITS-1:0]  modr;
  logic [CW-1:0]         c0;
  logic [CW-1:0]         c1;
  logic [CW-1:0]         prod;
  logic [WORD_BITS:0]    rem;
  logic [WORD_BITS-1:0]  dvd;
  logic [CNT_BITS-1:0]   cnt;
  logic                  out_valid;
  logic [WORD_BITS-1:0]  out_inverse;

  logic [WORD_BITS:0]    rem_sh;
  logic                  fits;
  logic [WORD_BITS:0]    rem_next;
  logic [CW-1:0]         prod_next;
  logic [CW-1:0]         mag;
  logic [CW-1:0]         mod_ext;
  logic [WORD_BITS-1:0]  result;
  logic                  req_fire;
  logic                  rsp_fire;
  logic                  out_free;

  assign req.ready   = (state == ST_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.inverse = out_inverse;
  assign rsp_fire    = out_valid && rsp.ready;
  assign out_free    = !out_valid || rsp.ready;

  // one restoring divide step plus shift-add of quotient bit times c1
  always_comb begin
    rem_sh    = {rem[WORD_BITS-1:0], dvd[WORD_BITS-1]};
    fits      = (rem_sh >= {1'b0, r1});
    rem_next  = fits ? (rem_sh - {1'b0, r1}) : rem_sh;
    prod_next = {prod[CW-2:0], 1'b0} + (fits ? c1 : '0);
  end

  // final reduction of the surviving coefficient into 0 .. modulus-1
  always_comb begin
    mag     = '0 - c0;
    mod_ext = {2'b00, modr};
    if (modr == '0) begin
      result = '0;
    end else if (c0[CW-1]) begin
      if (mag == mod_ext) begin
        result = '0;
      end else begin
        result = modr - mag[WORD_BITS-1:0];
      end
    end else if (c0 == mod_ext) begin
      result = '0;
    end else begin
      result = c0[WORD_BITS-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= (r1 == '0) ? ST_FINAL : ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_CHECK;
        end
        ST_FINAL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          r0   <= req.operand;
          r1   <= req.modulus;
          modr <= req.modulus;
          c0   <= CW'(1);
          c1   <= '0;
        end
      end
      ST_CHECK: begin
        rem  <= '0;
        dvd  <= r0;
        prod <= '0;
        cnt  <= CNT_BITS'(WORD_BITS - 1);
      end
      ST_DIV: begin
        rem  <= rem_next;
        dvd  <= {dvd[WORD_BITS-2:0], 1'b0};
        prod <= prod_next;
        cnt  <= cnt - 1'b1;
      end
      ST_UPDATE: begin
        r0 <= r1;
        r1 <= rem[WORD_BITS-1:0];
        c0 <= c1;
        c1 <= c0 - prod;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINAL && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL && out_free) begin
      out_inverse <= result;
    end
  end

endmodule : modular_inverse_unit

`default_nettype wire
